// File: rtl/core/sws_pkg.sv
// Shared types and constants of the searchable stack.
package sws_pkg;

  localparam int DATA_W          = 32;
  localparam int COUNT_OUT_W     = 7;
  localparam int STACK_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_INSERT = 2'd3
  } req_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_POP    = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

endpackage

// File: rtl/core/stack_with_search_edit.sv
// Bounded LIFO stack of 32-bit words with search-based remove and insert.
//
// Usage: one request per input transaction (push, pop, remove the first
// match of search_key from the top, or insert new_value just above that
// match). Each request gives exactly one result transaction carrying the
// popped value, found and full flags, the entry count and an empty flag.
// Both channels use valid and stall; a transaction moves when valid is high
// and stall is low. The block takes one request at a time and holds in_stall
// high until that request's result has been loaded into the output register.
// Steps: a push, and a pop, remove or insert on an empty stack, go from
// acceptance straight to the result state; any other pop first passes
// through ST_POP. Remove and insert search the entry memory one entry a
// cycle from the top, then shift the entries above the match one place a
// cycle through the memory; the longest request is a remove that matches
// the bottom entry of a full stack. The next request is taken in the cycle
// after the result is loaded. A result may wait in the output register
// while the next request is taken; a stall on the result side only delays
// the loading of the following result. Reset empties the stack at once (no
// clearing pass) and drops any pending result; no data read from an
// unwritten memory entry is ever used.
module stack_with_search_edit #(
  parameter int STACK_DEPTH = sws_pkg::STACK_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_req_type,
  input  logic signed [sws_pkg::DATA_W-1:0]      in_new_value,
  input  logic signed [sws_pkg::DATA_W-1:0]      in_search_key,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sws_pkg::DATA_W-1:0]      out_popped_value,
  output logic                                   out_popped_valid,
  output logic                                   out_key_found,
  output logic                                   out_full_error,
  output logic [sws_pkg::COUNT_OUT_W-1:0]        out_entry_count,
  output logic                                   out_is_empty
);
  import sws_pkg::*;

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   scan_r, scan_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [DATA_W-1:0]   key_r, key_nxt;
  logic [DATA_W-1:0]   res_popped_r, res_popped_nxt;
  logic                res_pvalid_r, res_pvalid_nxt;
  logic                res_found_r, res_found_nxt;
  logic                res_full_r, res_full_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_popped_r, out_popped_nxt;
  logic                out_pvalid_r, out_pvalid_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_full_r, out_full_nxt;
  logic [COUNT_OUT_W-1:0] out_count_r, out_count_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic [CNT_W-1:0]    cnt_dec;
  logic [ADDR_W-1:0]   cnt_m1;
  logic                is_full;
  logic                key_hit;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

  assign cnt_dec  = count_r - CNT_W'(1);
  assign cnt_m1   = cnt_dec[ADDR_W-1:0];
  assign is_full  = (count_r == CNT_W'(STACK_DEPTH));
  assign key_hit  = (rdata_r == key_r);
  assign cnt_wide = {{COUNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    key_nxt        = key_r;
    res_popped_nxt = res_popped_r;
    res_pvalid_nxt = res_pvalid_r;
    res_found_nxt  = res_found_r;
    res_full_nxt   = res_full_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_popped_nxt = out_popped_r;
    out_pvalid_nxt = out_pvalid_r;
    out_found_nxt  = out_found_r;
    out_full_nxt   = out_full_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[ADDR_W-1:0];
    mem_wdata      = in_new_value;
    mem_raddr      = cnt_m1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt        = req_t'(in_req_type);
          val_nxt        = in_new_value;
          key_nxt        = in_search_key;
          res_popped_nxt = '0;
          res_pvalid_nxt = 1'b0;
          res_found_nxt  = 1'b0;
          res_full_nxt   = 1'b0;
          state_nxt      = ST_RESULT;
          unique case (req_t'(in_req_type)) inside
            REQ_PUSH: begin
              if (is_full) begin
                res_full_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_POP: begin
              if (count_r != '0) begin
                count_nxt = cnt_dec;
                state_nxt = ST_POP;
              end
            end
            REQ_REMOVE, REQ_INSERT: begin
              if (count_r != '0) begin
                scan_nxt  = cnt_m1;
                state_nxt = ST_SEARCH;
              end
            end
          endcase
        end
      end
      ST_POP: begin
        res_popped_nxt = rdata_r;
        res_pvalid_nxt = 1'b1;
        state_nxt      = ST_RESULT;
      end
      ST_SEARCH: begin
        if (key_hit) begin
          res_found_nxt = 1'b1;
          pos_nxt       = scan_r;
          if (req_r == REQ_REMOVE) begin
            if (scan_r == cnt_m1) begin
              count_nxt = cnt_dec;
              state_nxt = ST_RESULT;
            end else begin
              scan_nxt  = scan_r + ADDR_W'(1);
              mem_raddr = scan_r + ADDR_W'(1);
              state_nxt = ST_SHIFT;
            end
          end else if (is_full) begin
            res_full_nxt = 1'b1;
            state_nxt    = ST_RESULT;
          end else if (scan_r == cnt_m1) begin
            state_nxt = ST_FILL;
          end else begin
            scan_nxt  = cnt_m1;
            mem_raddr = cnt_m1;
            state_nxt = ST_SHIFT;
          end
        end else if (scan_r == '0) begin
          state_nxt = ST_RESULT;
        end else begin
          scan_nxt  = scan_r - ADDR_W'(1);
          mem_raddr = scan_r - ADDR_W'(1);
        end
      end
      ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        if (req_r == REQ_REMOVE) begin
          mem_waddr = scan_r - ADDR_W'(1);
          if (scan_r == cnt_m1) begin
            count_nxt = cnt_dec;
            state_nxt = ST_RESULT;
          end else begin
            scan_nxt  = scan_r + ADDR_W'(1);
            mem_raddr = scan_r + ADDR_W'(1);
          end
        end else begin
          mem_waddr = scan_r + ADDR_W'(1);
          if (scan_r == pos_r + ADDR_W'(1)) begin
            state_nxt = ST_FILL;
          end else begin
            scan_nxt  = scan_r - ADDR_W'(1);
            mem_raddr = scan_r - ADDR_W'(1);
          end
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r + ADDR_W'(1);
        mem_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_popped_nxt = res_popped_r;
          out_pvalid_nxt = res_pvalid_r;
          out_found_nxt  = res_found_r;
          out_full_nxt   = res_full_r;
          out_count_nxt  = cnt_wide[COUNT_OUT_W-1:0];
          out_empty_nxt  = (count_r == '0);
          state_nxt      = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    scan_r       <= scan_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    key_r        <= key_nxt;
    res_popped_r <= res_popped_nxt;
    res_pvalid_r <= res_pvalid_nxt;
    res_found_r  <= res_found_nxt;
    res_full_r   <= res_full_nxt;
    out_popped_r <= out_popped_nxt;
    out_pvalid_r <= out_pvalid_nxt;
    out_found_r  <= out_found_nxt;
    out_full_r   <= out_full_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_popped_valid = out_pvalid_r;
  assign out_key_found    = out_found_r;
  assign out_full_error   = out_full_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;

endmodule

// File: rtl/core/sws_checker.sv
// Port-level checks on the searchable stack, bound to its top level.
module sws_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [sws_pkg::DATA_W-1:0] out_popped_value,
  input logic                              out_popped_valid,
  input logic                              out_key_found,
  input logic                              out_full_error,
  input logic [sws_pkg::COUNT_OUT_W-1:0]   out_entry_count,
  input logic                              out_is_empty
);
  import sws_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_popped_value)
      && $stable(out_entry_count))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in back-to-back cycles");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_entry_count != '0) |-> !out_is_empty)
    else $error("empty flag set with entries present");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_popped_valid |-> !out_key_found && !out_full_error)
    else $error("pop result carries search or full flags");

  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_popped_valid |-> (out_popped_value == '0))
    else $error("popped value non-zero without a pop");

endmodule

bind stack_with_search_edit sws_checker u_sws_checker (.*);
